>>> rtl/t2u_pkg.sv
// Shared types and constants for the text to UTF-16 transcoder.
// No dependencies.
package t2u_pkg;

  typedef enum logic [1:0] {
    SRC_WIN1252 = 2'd0,
    SRC_UTF8    = 2'd1,
    SRC_UTF16   = 2'd2,
    SRC_NONE    = 2'd3
  } enc_t;

  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  typedef struct packed {
    logic [15:0] utf16_unit;
    logic [15:0] char_count;
    logic        last;
  } res_t;

  // up to two results from one source unit
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } dec_out_t;

  // CP1252 bytes 0x80-0x9F; undefined slots give zero
  function automatic logic [15:0] cp1252_hi(input logic [4:0] idx);
    logic [15:0] u;
    case (idx)
      5'd0:  u = 16'h20AC;
      5'd1:  u = 16'h0000;
      5'd2:  u = 16'h201A;
      5'd3:  u = 16'h0192;
      5'd4:  u = 16'h201E;
      5'd5:  u = 16'h2026;
      5'd6:  u = 16'h2020;
      5'd7:  u = 16'h2021;
      5'd8:  u = 16'h02C6;
      5'd9:  u = 16'h2030;
      5'd10: u = 16'h0160;
      5'd11: u = 16'h2039;
      5'd12: u = 16'h0152;
      5'd13: u = 16'h0000;
      5'd14: u = 16'h017D;
      5'd15: u = 16'h0000;
      5'd16: u = 16'h0000;
      5'd17: u = 16'h2018;
      5'd18: u = 16'h2019;
      5'd19: u = 16'h201C;
      5'd20: u = 16'h201D;
      5'd21: u = 16'h2022;
      5'd22: u = 16'h2013;
      5'd23: u = 16'h2014;
      5'd24: u = 16'h02DC;
      5'd25: u = 16'h2122;
      5'd26: u = 16'h0161;
      5'd27: u = 16'h203A;
      5'd28: u = 16'h0153;
      5'd29: u = 16'h0000;
      5'd30: u = 16'h017E;
      5'd31: u = 16'h0178;
      default: u = 16'h0000;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/t2u_decode.sv
// Per-unit decoder: source unit plus sequence state to zero, one or two UTF-16 results.
// Holds the UTF-8 accumulator and the character counter. Depends on t2u_pkg.
module t2u_decode #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              clr_seq,
  input  t2u_pkg::enc_t     enc,
  input  logic [15:0]       unit,
  output t2u_pkg::dec_out_t dec
);
  import t2u_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};

  logic [20:0]           part_r, part_nxt;
  logic [1:0]            pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [7:0]            b;
  logic                  term;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [20:0]           acc;
  logic                  emit_en;
  logic [20:0]           emit_cp;
  logic [19:0]           v;

  function automatic logic [15:0] cnt_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] ext;
    ext = 32'(c);
    return (ext > 32'h0000_FFFF) ? 16'hFFFF : ext[15:0];
  endfunction

  always_comb begin
    b       = unit[7:0];
    term    = enc[1] ? (unit == 16'h0000) : (b == 8'h00);
    cnt_inc = (cnt_r == CNT_TOP) ? cnt_r : cnt_r + 1'b1;
    acc     = {part_r[14:0], b[5:0]};
    emit_en = 1'b0;
    emit_cp = '0;
    v       = '0;

    part_nxt = part_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    dec      = '0;

    if (term) begin
      dec.num  = 2'd1;
      dec.res0 = '{utf16_unit: 16'h0000, char_count: cnt_out(cnt_r), last: 1'b1};
      cnt_nxt  = '0;
      part_nxt = '0;
      pend_nxt = '0;
    end else begin
      case (enc)
        SRC_WIN1252: begin
          cnt_nxt  = cnt_inc;
          dec.num  = 2'd1;
          dec.res0.utf16_unit = (b[7:5] == 3'b100) ? cp1252_hi(b[4:0]) : {8'h00, b};
          dec.res0.char_count = cnt_out(cnt_inc);
        end
        SRC_UTF8: begin
          if (pend_r != 2'd0) begin
            pend_nxt = pend_r - 2'd1;
            if (pend_r == 2'd1) begin
              part_nxt = '0;
              emit_en  = 1'b1;
              emit_cp  = acc;
            end else begin
              part_nxt = acc;
            end
          end else if (b[7:5] == 3'b110) begin
            part_nxt = {16'h0000, b[4:0]};
            pend_nxt = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            part_nxt = {17'h00000, b[3:0]};
            pend_nxt = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            part_nxt = {18'h00000, b[2:0]};
            pend_nxt = 2'd3;
          end else begin
            // ASCII or stray byte goes out as itself
            emit_en = 1'b1;
            emit_cp = {13'h0000, b};
          end
        end
        SRC_UTF16: begin
          // low surrogates ride along uncounted
          if (unit[15:10] != 6'b110111) begin
            cnt_nxt = cnt_inc;
          end
          dec.num  = 2'd1;
          dec.res0.utf16_unit = unit;
          dec.res0.char_count = cnt_out(cnt_nxt);
        end
        default: begin
        end
      endcase

      if (emit_en) begin
        cnt_nxt = cnt_inc;
        dec.res0.char_count = cnt_out(cnt_inc);
        dec.res1.char_count = cnt_out(cnt_inc);
        if (emit_cp[20:16] != 5'd0) begin
          v = 20'(emit_cp - SUPP_BASE);
          dec.num = 2'd2;
          dec.res0.utf16_unit = HI_SURR_BASE | {6'h00, v[19:10]};
          dec.res1.utf16_unit = LO_SURR_BASE | {6'h00, v[9:0]};
        end else begin
          dec.num = 2'd1;
          dec.res0.utf16_unit = emit_cp[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
    end else if (clr_seq) begin
      part_r <= '0;
      pend_r <= '0;
    end else if (step) begin
      part_r <= part_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> rtl/t2u_out_buf.sv
// Two-entry result buffer: takes up to two results a cycle, hands out one per beat.
// Depends on t2u_pkg.
module t2u_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_num,
  input  t2u_pkg::res_t push0,
  input  t2u_pkg::res_t push1,
  output logic [1:0]    space,
  output logic          out_valid,
  input  logic          out_ready,
  output t2u_pkg::res_t out_res
);
  import t2u_pkg::*;

  res_t       e0_r, e0_nxt;
  res_t       e1_r, e1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] rem;
  res_t       base0;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = e0_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    rem    = cnt_r - {1'b0, pop};
    base0  = (pop) ? e1_r : e0_r;
    space  = 2'd2 - rem;
    e0_nxt = base0;
    e1_nxt = e1_r;
    if (rem == 2'd0) begin
      e0_nxt = push0;
      e1_nxt = push1;
    end else if (rem == 2'd1) begin
      e1_nxt = push0;
    end
    cnt_nxt = rem + push_num;
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/text_to_utf16_transcoder_unit.sv
// Top level of the text to UTF-16 transcoder: input register, decoder, result buffer.
// Depends on t2u_pkg, t2u_decode and t2u_out_buf.
//
//   group  dir  payload                                   beat when
//   in_    in   tdata[15:0] code_unit                     in_tvalid & in_tready
//   out_   out  tdata[15:0] utf16_unit, [31:16] char_count, tlast   out_tvalid & out_tready
//   cfg_   in   data[1:0] source_encoding                 cfg_valid & cfg_ready
//
// One input beat per cycle while the two-entry result buffer has room; each unit is
// registered in the input register, then in the result buffer. A surrogate pair takes two
// output beats, so input can stall after a pair even when the output side keeps pace.
// Synchronous reset clears the control state and count; sets source_encoding to UTF-8.
// A stalled output backs up through the buffer into the input register.
module text_to_utf16_transcoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] code_unit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] utf16_unit, [31:16] char_count
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data     // [1:0] source_encoding
);
  import t2u_pkg::*;

  enc_t        enc_r;
  logic        iv_r;
  logic [15:0] unit_r;
  dec_out_t    dec;
  logic [1:0]  space;
  logic        adv;
  logic        cfg_wr;
  res_t        out_res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign adv       = iv_r && (dec.num <= space);
  assign in_tready = !iv_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= SRC_UTF8;
      iv_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        enc_r <= enc_t'(cfg_data);
      end
      if (in_tready) begin
        iv_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      unit_r <= in_tdata;
    end
  end

  t2u_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .clr_seq (cfg_wr),
    .enc     (enc_r),
    .unit    (unit_r),
    .dec     (dec)
  );

  t2u_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (adv ? dec.num : 2'd0),
    .push0     (dec.res0),
    .push1     (dec.res1),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.char_count, out_res.utf16_unit};
  assign out_tlast = out_res.last;

endmodule
